@@ rtl/core/psr_pkg.sv @@
// Shared types and constants for the printer serial packet receiver.
// No dependencies; psr_image_buf.sv and the receiver core import this package.
package psr_pkg;

    localparam int DEF_PAYLOAD_DEPTH = 1024;
    localparam int DEF_IMAGE_DEPTH   = 8192;

    localparam logic [7:0] MAGIC_FIRST  = 8'h88;
    localparam logic [7:0] MAGIC_SECOND = 8'h33;
    localparam logic [7:0] ALIVE_REPLY  = 8'h81;

    // image fill level at which the printer reports itself full
    localparam int IMG_FULL_MARK = 'h27f;

    localparam logic [7:0] CMD_INIT        = 8'd1;
    localparam logic [7:0] CMD_PRINT       = 8'd2;
    localparam logic [7:0] CMD_GRAPHICS    = 8'd4;
    localparam logic [7:0] CMD_READ_STATUS = 8'd15;

    localparam logic [3:0] STAT_CLEAR    = 4'd0;
    localparam logic [3:0] STAT_PRINTING = 4'd4;
    localparam logic [3:0] STAT_FULL     = 4'd8;

    // packet framing phase
    typedef enum logic [10:0] {
        PH_MAGIC1   = 11'b000_0000_0001,
        PH_MAGIC2   = 11'b000_0000_0010,
        PH_COMMAND  = 11'b000_0000_0100,
        PH_COMPRESS = 11'b000_0000_1000,
        PH_LEN_LO   = 11'b000_0001_0000,
        PH_LEN_HI   = 11'b000_0010_0000,
        PH_DATA     = 11'b000_0100_0000,
        PH_CHK_LO   = 11'b000_1000_0000,
        PH_CHK_HI   = 11'b001_0000_0000,
        PH_ALIVE    = 11'b010_0000_0000,
        PH_STATUS   = 11'b100_0000_0000
    } t_phase;

    // command execution sequencer
    typedef enum logic [2:0] {
        CTL_IDLE = 3'b001,
        CTL_COPY = 3'b010,
        CTL_PRT  = 3'b100
    } t_ctl;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       print_start;
        logic [3:0] pre_margin;
        logic [3:0] post_margin;
        logic [7:0] palette;
        logic [6:0] exposure;
        logic [13:0] image_bytes;
    } t_tx_beat;

    // control from the sequencer to the image buffer
    typedef struct packed {
        logic       clear;
        logic       push;
        logic [7:0] data;
    } t_img_ctl;

endpackage

@@ rtl/core/psr_if.sv @@
// Valid/ready channel interfaces for the printer serial packet receiver.
// psr_rx_if carries host bytes in, psr_tx_if carries reply beats out; no dependencies.
interface psr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psr_tx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        print_start;
    logic [3:0]  pre_margin;
    logic [3:0]  post_margin;
    logic [7:0]  palette;
    logic [6:0]  exposure;
    logic [13:0] image_bytes;

    modport source (output valid, output tx_byte, output print_start, output pre_margin,
                    output post_margin, output palette, output exposure, output image_bytes,
                    input ready);
    modport sink   (input valid, input tx_byte, input print_start, input pre_margin,
                    input post_margin, input palette, input exposure, input image_bytes,
                    output ready);
endinterface

@@ rtl/core/psr_image_buf.sv @@
// Image memory and its fill counter for the printer serial packet receiver.
// Depends on psr_pkg for the control struct; the caller keeps pushes below IMAGE_DEPTH.
module psr_image_buf #(
    parameter int IMAGE_DEPTH = psr_pkg::DEF_IMAGE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  psr_pkg::t_img_ctl                  i_ctl,
    output logic [$clog2(IMAGE_DEPTH):0]       o_count
);
    import psr_pkg::*;

    localparam int AW = $clog2(IMAGE_DEPTH);
    localparam int CW = AW + 1;

    logic [7:0]    mem_img [IMAGE_DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem_img[r_count[AW-1:0]] <= i_ctl.data;
        end
    end

    assign o_count = r_count;

endmodule

@@ rtl/core/printer_serial_packet_receiver_core.sv @@
// Printer serial packet receiver: frames host bytes and answers one reply beat per byte.
// Most reply beats are registered straight from their byte; a print status byte first takes three
// payload reads through the registered read port, and a graphics status byte first copies n bytes
// (min(length, PAYLOAD_DEPTH), fewer once the image is full) to the image; the copy
// moves one byte a cycle, set by the single payload read port. Input is held off meanwhile.
// Reset: synchronous, active low; clears framing, status and image count. The payload and
// image memories are not cleared and need no clearing pass.
module printer_serial_packet_receiver_core #(
    parameter int PAYLOAD_DEPTH = psr_pkg::DEF_PAYLOAD_DEPTH,
    parameter int IMAGE_DEPTH   = psr_pkg::DEF_IMAGE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psr_rx_if.sink        i_rx,
    psr_tx_if.source      o_tx
);
    import psr_pkg::*;

    localparam int PW  = $clog2(PAYLOAD_DEPTH);
    localparam int CNW = PW + 1;
    localparam int IW  = $clog2(IMAGE_DEPTH) + 1;

    t_phase        r_phase, n_phase;
    t_ctl          r_ctl, n_ctl;
    logic [7:0]    r_cmd, n_cmd;
    logic [15:0]   r_len, n_len;
    logic [15:0]   r_idx, n_idx;
    logic [3:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    t_tx_beat      r_out, n_out;
    logic [CNW-1:0] r_cidx, n_cidx;
    logic [CNW-1:0] r_copy_n, n_copy_n;
    logic          r_pend, n_pend;
    logic [1:0]    r_step, n_step;

    logic [7:0]    mem_pay [PAYLOAD_DEPTH];
    logic [7:0]    r_rd;
    logic          pay_we, pay_re;
    logic [PW-1:0] pay_wa, pay_ra;

    t_img_ctl      img_ctl;
    logic [IW-1:0] w_count;

    logic          rx_fire, tx_fire, issue, load;
    logic [7:0]    b;
    logic [15:0]   len_full, idx_inc;
    t_tx_beat      beat;

    psr_image_buf #(
        .IMAGE_DEPTH (IMAGE_DEPTH)
    ) u_image_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (img_ctl),
        .o_count (w_count)
    );

    assign rx_fire    = i_rx.valid && i_rx.ready;
    assign tx_fire    = o_tx.valid && o_tx.ready;
    assign b          = i_rx.rx_byte;
    assign len_full   = {b, r_len[7:0]};
    assign idx_inc    = r_idx + 16'd1;
    assign i_rx.ready = (r_ctl == CTL_IDLE) && (!r_out_valid || o_tx.ready);

    always_comb begin
        n_phase     = r_phase;
        n_ctl       = r_ctl;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_idx       = r_idx;
        n_status    = r_status;
        n_out_valid = r_out_valid && !tx_fire;
        n_out       = r_out;
        n_cidx      = r_cidx;
        n_copy_n    = r_copy_n;
        n_pend      = r_pend;
        n_step      = r_step;
        pay_we      = 1'b0;
        pay_wa      = r_idx[PW-1:0];
        pay_re      = 1'b0;
        pay_ra      = r_cidx[PW-1:0];
        img_ctl     = '0;
        img_ctl.data = r_rd;
        issue       = 1'b0;
        load        = 1'b1;
        beat        = '0;
        beat.image_bytes = 14'(w_count);

        unique case (r_ctl)
            CTL_IDLE: begin
                if (rx_fire) begin
                    unique case (r_phase)
                        PH_MAGIC1: begin
                            if (b == MAGIC_FIRST) n_phase = PH_MAGIC2;
                        end
                        PH_MAGIC2: begin
                            n_phase = (b == MAGIC_SECOND) ? PH_COMMAND : PH_MAGIC1;
                        end
                        PH_COMMAND: begin
                            n_cmd   = b;
                            n_phase = PH_COMPRESS;
                        end
                        PH_COMPRESS: n_phase = PH_LEN_LO;
                        PH_LEN_LO: begin
                            n_len   = {8'd0, b};
                            n_phase = PH_LEN_HI;
                        end
                        PH_LEN_HI: begin
                            n_len   = len_full;
                            n_idx   = '0;
                            n_phase = (len_full != 16'd0) ? PH_DATA : PH_CHK_LO;
                        end
                        PH_DATA: begin
                            // drop bytes beyond the payload store
                            pay_we = ({1'b0, r_idx} < 17'(PAYLOAD_DEPTH));
                            n_idx  = idx_inc;
                            if (idx_inc == r_len) n_phase = PH_CHK_LO;
                        end
                        PH_CHK_LO: n_phase = PH_CHK_HI;
                        PH_CHK_HI: n_phase = PH_ALIVE;
                        PH_ALIVE: begin
                            beat.tx_byte = ALIVE_REPLY;
                            n_phase = (b == 8'd0) ? PH_STATUS : PH_MAGIC1;
                        end
                        PH_STATUS: begin
                            n_phase = PH_MAGIC1;
                            case (r_cmd)
                                CMD_INIT: begin
                                    img_ctl.clear    = 1'b1;
                                    n_status         = STAT_CLEAR;
                                    beat.image_bytes = '0;
                                end
                                CMD_PRINT: begin
                                    beat.tx_byte     = {4'd0, r_status};
                                    beat.print_start = 1'b1;
                                    n_status         = STAT_PRINTING;
                                    load             = 1'b0;
                                    n_ctl            = CTL_PRT;
                                    n_step           = 2'd0;
                                end
                                CMD_GRAPHICS: begin
                                    load     = 1'b0;
                                    n_ctl    = CTL_COPY;
                                    n_cidx   = '0;
                                    n_pend   = 1'b0;
                                    n_copy_n = ({1'b0, r_len} > 17'(PAYLOAD_DEPTH))
                                             ? CNW'(PAYLOAD_DEPTH) : CNW'(r_len);
                                end
                                CMD_READ_STATUS: beat.tx_byte = {4'd0, r_status};
                                default: ;
                            endcase
                        end
                        default: n_phase = PH_MAGIC1;
                    endcase
                    // output register is free here: empty, or draining on this edge
                    n_out       = beat;
                    n_out_valid = load;
                end
            end
            CTL_COPY: begin
                // read one payload byte ahead, write it to the image once it is registered
                issue = (r_cidx < r_copy_n)
                     && ((w_count + IW'(r_pend)) < IW'(IMAGE_DEPTH));
                if (r_pend) begin
                    img_ctl.push = 1'b1;
                end
                if (issue) begin
                    pay_re = 1'b1;
                    n_cidx = r_cidx + CNW'(1);
                end
                n_pend = issue;
                if (!r_pend && !issue) begin
                    if (w_count >= IW'(IMG_FULL_MARK)) n_status = STAT_FULL;
                    n_out.image_bytes = 14'(w_count);
                    n_out_valid = 1'b1;
                    n_ctl       = CTL_IDLE;
                end
            end
            CTL_PRT: begin
                case (r_step)
                    2'd0: begin
                        pay_re = 1'b1;
                        pay_ra = PW'(1);
                        n_step = 2'd1;
                    end
                    2'd1: begin
                        n_out.pre_margin  = r_rd[7:4];
                        n_out.post_margin = r_rd[3:0];
                        pay_re = 1'b1;
                        pay_ra = PW'(2);
                        n_step = 2'd2;
                    end
                    2'd2: begin
                        n_out.palette = r_rd;
                        pay_re = 1'b1;
                        pay_ra = PW'(3);
                        n_step = 2'd3;
                    end
                    default: begin
                        n_out.exposure = r_rd[6:0];
                        n_out_valid    = 1'b1;
                        n_ctl          = CTL_IDLE;
                    end
                endcase
            end
            default: n_ctl = CTL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC1;
            r_ctl       <= CTL_IDLE;
            r_cmd       <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_status    <= STAT_CLEAR;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_step      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_ctl       <= n_ctl;
            r_cmd       <= n_cmd;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_cidx   <= n_cidx;
        r_copy_n <= n_copy_n;
    end

    // payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            mem_pay[pay_wa] <= b;
        end
        if (pay_re) begin
            r_rd <= mem_pay[pay_ra];
        end
    end

    assign o_tx.valid        = r_out_valid;
    assign o_tx.tx_byte      = r_out.tx_byte;
    assign o_tx.print_start  = r_out.print_start;
    assign o_tx.pre_margin   = r_out.pre_margin;
    assign o_tx.post_margin  = r_out.post_margin;
    assign o_tx.palette      = r_out.palette;
    assign o_tx.exposure     = r_out.exposure;
    assign o_tx.image_bytes  = r_out.image_bytes;

endmodule
